[hdl/mvn_pkg.sv]
// Shared types and constants of the mesh vertex normal unit.
// No dependencies; every other file refers to this package by scoped names.
package mvn_pkg;

	localparam int IDX_W = 10;
	localparam int POS_W = 32;
	localparam int NRM_W = 16;
	localparam int SUM_W = 24;
	localparam int DIF_W = 33;
	localparam int RED_W = 31;
	localparam int CRS_W = 64;
	localparam int QUO_W = 15;
	localparam int DIV_W = 47;
	localparam int UNIT_SH = 14;
	localparam int DEF_MAX_VERTICES = 1024;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SUM_W-1:0] SUM_MAX = 24'h7FFFFF;
	localparam logic [SUM_W-1:0] SUM_MIN = 24'h800000;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_FACE  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_FACE,
		OP_READ,
		OP_READ_OOR
	} op_t;

	typedef enum logic [3:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_FA,
		BK_FB,
		BK_FC,
		BK_SHIFT,
		BK_MUL,
		BK_NGO,
		BK_NF,
		BK_ACC_RD,
		BK_ACC_WR,
		BK_RS,
		BK_RN,
		BK_OUT
	} bk_state_t;

	typedef enum logic [2:0] {
		NM_IDLE,
		NM_SHIFT,
		NM_SQ,
		NM_SQRT,
		NM_DINIT,
		NM_DIV
	} nm_state_t;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [IDX_W-1:0]        vertex_index;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [IDX_W-1:0]        corner_a;
		logic [IDX_W-1:0]        corner_b;
		logic [IDX_W-1:0]        corner_c;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_index;
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic                    zero_normal;
	} rsp_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic [POS_W-1:0] pz;
		logic [IDX_W-1:0] ca;
		logic [IDX_W-1:0] cb;
		logic [IDX_W-1:0] cc;
	} qent_t;

	typedef struct packed {
		logic  valid;
		qent_t ent;
	} fr_head_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} bk_ctl_t;

endpackage

[hdl/mvn_front.sv]
// Front end: takes requests, classifies them and queues the ones with work.
// Depends on mvn_pkg.
module mvn_front #(
	parameter int MAX_VERTICES = mvn_pkg::DEF_MAX_VERTICES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  mvn_pkg::req_t      req,
	output mvn_pkg::fr_head_t  head,
	input  mvn_pkg::bk_ctl_t   ctl
);

	localparam int QD = mvn_pkg::QUEUE_DEPTH;
	localparam int PW = mvn_pkg::QPTR_W;
	localparam int CW = mvn_pkg::QCNT_W;

	mvn_pkg::qent_t q_mem [QD];
	logic [PW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;

	mvn_pkg::qent_t ent;
	logic           keep, push, pop, idx_ok, corners_ok;

	always_comb begin
		idx_ok     = 32'(req.vertex_index) < MAX_VERTICES;
		corners_ok = (32'(req.corner_a) < MAX_VERTICES) && (32'(req.corner_b) < MAX_VERTICES)
			&& (32'(req.corner_c) < MAX_VERTICES);
		ent.idx = req.vertex_index;
		ent.px  = req.pos_x;
		ent.py  = req.pos_y;
		ent.pz  = req.pos_z;
		ent.ca  = req.corner_a;
		ent.cb  = req.corner_b;
		ent.cc  = req.corner_c;
		ent.op  = mvn_pkg::OP_WRITE;
		keep    = 1'b0;
		case (req.cmd)
			mvn_pkg::CMD_WRITE: begin
				keep = idx_ok;
			end
			mvn_pkg::CMD_FACE: begin
				keep   = corners_ok;
				ent.op = mvn_pkg::OP_FACE;
			end
			mvn_pkg::CMD_READ: begin
				keep   = 1'b1;
				ent.op = idx_ok ? mvn_pkg::OP_READ : mvn_pkg::OP_READ_OOR;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign req_ready  = (cnt_q != CW'(QD)) && !ctl.clearing;
	assign push       = req_valid && req_ready && keep;
	assign pop        = ctl.pop;
	assign head.valid = (cnt_q != '0);
	assign head.ent   = q_mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wp_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QD - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(QD - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hdl/mvn_norm.sv]
// Vector normalizer: scales a signed vector to a Q1.14 unit vector using a
// shared squarer, a bit-pair square root and a restoring divider. Depends on mvn_pkg.
module mvn_norm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [2:0][mvn_pkg::CRS_W-1:0]      vin,
	output logic                                done,
	output logic                                zero,
	output logic [2:0][mvn_pkg::NRM_W-1:0]      q
);

	localparam int CW = mvn_pkg::CRS_W;
	localparam int RW = mvn_pkg::RED_W;
	localparam int NW = mvn_pkg::NRM_W;
	localparam int DV = mvn_pkg::DIV_W;
	localparam int QW = mvn_pkg::QUO_W;
	localparam int SH = mvn_pkg::UNIT_SH;

	mvn_pkg::nm_state_t st_q, nxt;

	logic [4:0]            k_q;
	logic [1:0]            j_q;
	logic                  done_q, zero_q;
	logic [2:0]            neg_q;
	logic [2:0][CW-1:0]    m_q;
	logic [2*RW-1:0]       sq_q;
	logic [CW-1:0]         acc_q, rv_q, rr_q, bit_q;
	logic [DV-1:0]         rem_q, dvs_q;
	logic [QW-2:0]         quo_q;
	logic [2:0][NW-1:0]    res_q;

	logic                  allz, big, sq_ge, dge;
	logic [CW-1:0]         sqt;
	logic [RW-1:0]         mk;
	logic [2*RW-1:0]       sqp;
	logic [QW-1:0]         qfin;

	always_comb begin
		allz  = (vin == '0);
		big   = (|m_q[0][CW-1:RW]) || (|m_q[1][CW-1:RW]) || (|m_q[2][CW-1:RW]);
		sqt   = rr_q + bit_q;
		sq_ge = rv_q >= sqt;
		dge   = rem_q >= dvs_q;
		qfin  = {quo_q, dge};
		mk    = m_q[k_q[1:0]][RW-1:0];
		sqp   = mk * mk;
	end

	always_comb begin
		nxt = st_q;
		case (st_q)
			mvn_pkg::NM_IDLE:  if (start && !allz) nxt = mvn_pkg::NM_SHIFT;
			mvn_pkg::NM_SHIFT: if (!big) nxt = mvn_pkg::NM_SQ;
			mvn_pkg::NM_SQ:    if (k_q == 5'd3) nxt = mvn_pkg::NM_SQRT;
			mvn_pkg::NM_SQRT:  if (k_q == 5'd31) nxt = mvn_pkg::NM_DINIT;
			mvn_pkg::NM_DINIT: nxt = mvn_pkg::NM_DIV;
			mvn_pkg::NM_DIV: begin
				if (k_q == 5'(QW - 1)) begin
					nxt = (j_q == 2'd2) ? mvn_pkg::NM_IDLE : mvn_pkg::NM_DINIT;
				end
			end
			default: nxt = mvn_pkg::NM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= mvn_pkg::NM_IDLE;
			k_q    <= '0;
			j_q    <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= nxt;
			done_q <= 1'b0;
			case (st_q)
				mvn_pkg::NM_IDLE:  if (start) done_q <= allz;
				mvn_pkg::NM_SHIFT: if (!big) k_q <= '0;
				mvn_pkg::NM_SQ:    k_q <= (k_q == 5'd3) ? '0 : k_q + 1'b1;
				mvn_pkg::NM_SQRT: begin
					k_q <= k_q + 1'b1;
					if (k_q == 5'd31) begin
						k_q <= '0;
						j_q <= '0;
					end
				end
				mvn_pkg::NM_DINIT: k_q <= '0;
				mvn_pkg::NM_DIV: begin
					k_q <= k_q + 1'b1;
					if (k_q == 5'(QW - 1)) begin
						if (j_q == 2'd2) begin
							done_q <= 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			mvn_pkg::NM_IDLE: begin
				if (start) begin
					zero_q <= allz;
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= vin[i][CW-1];
						m_q[i]   <= vin[i][CW-1] ? -vin[i] : vin[i];
					end
					if (allz) begin
						res_q <= '0;
					end
				end
			end
			mvn_pkg::NM_SHIFT: begin
				if (big) begin
					for (int i = 0; i < 3; i++) begin
						m_q[i] <= m_q[i] >> 1;
					end
				end else begin
					acc_q <= '0;
				end
			end
			mvn_pkg::NM_SQ: begin
				if (k_q != 5'd3) begin
					sq_q <= sqp;
				end
				if (k_q == 5'd1 || k_q == 5'd2) begin
					acc_q <= acc_q + CW'(sq_q);
				end
				if (k_q == 5'd3) begin
					rv_q  <= acc_q + CW'(sq_q);
					rr_q  <= '0;
					bit_q <= CW'(1) << (CW - 2);
				end
			end
			mvn_pkg::NM_SQRT: begin
				if (sq_ge) begin
					rv_q <= rv_q - sqt;
					rr_q <= (rr_q >> 1) + bit_q;
				end else begin
					rr_q <= rr_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			mvn_pkg::NM_DINIT: begin
				// numerator carries half the magnitude for round-half-up
				rem_q <= DV'({m_q[j_q][RW-1:0], SH'(0)}) + DV'(rr_q[31:1]);
				dvs_q <= DV'({rr_q[31:0], SH'(0)});
				quo_q <= '0;
			end
			mvn_pkg::NM_DIV: begin
				if (dge) begin
					rem_q <= rem_q - dvs_q;
				end
				quo_q <= qfin[QW-2:0];
				dvs_q <= dvs_q >> 1;
				if (k_q == 5'(QW - 1)) begin
					res_q[j_q] <= neg_q[j_q] ? -NW'(qfin) : NW'(qfin);
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign zero = zero_q;
	assign q    = res_q;

endmodule

[hdl/mvn_back.sv]
// Back end: vertex and normal-sum memories, face cross product, accumulation,
// read-and-clear and the result register. Depends on mvn_pkg and mvn_norm.
module mvn_back #(
	parameter int MAX_VERTICES = mvn_pkg::DEF_MAX_VERTICES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mvn_pkg::fr_head_t head,
	output mvn_pkg::bk_ctl_t  ctl,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output mvn_pkg::rsp_t     rsp
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int IW = mvn_pkg::IDX_W;
	localparam int EW = (AW > IW) ? AW : IW;
	localparam int SW = mvn_pkg::SUM_W;
	localparam int PW = mvn_pkg::POS_W;
	localparam int DW = mvn_pkg::DIF_W;
	localparam int RW = mvn_pkg::RED_W;
	localparam int CW = mvn_pkg::CRS_W;
	localparam int NW = mvn_pkg::NRM_W;

	typedef logic [2:0][SW-1:0] sums_t;
	typedef logic [2:0][PW-1:0] vpos_t;

	function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] i);
		logic [EW-1:0] e;
		e = EW'(i);
		return e[AW-1:0];
	endfunction

	vpos_t vmem [MAX_VERTICES];
	sums_t smem [MAX_VERTICES];

	mvn_pkg::bk_state_t st_q, nxt;

	logic [AW-1:0]       clr_q, ia_q, ib_q, ic_q, raddr_q;
	logic [IW-1:0]       ridx_q;
	logic [2:0]          k_q;
	logic [1:0]          cn_q;
	logic                rsp_valid_q;
	mvn_pkg::rsp_t       rsp_q;
	vpos_t               vrd_q, va_q, vb_q;
	sums_t               srd_q;
	logic [5:0][DW-1:0]  d_q;
	logic [5:0][RW-1:0]  ds_q;
	logic signed [2*RW-1:0] prod_q;
	logic [2:0][CW-1:0]  cr_q;

	logic [AW-1:0]       vaddr, saddr, swaddr, cn_addr;
	logic                vwe, swe, pop, nstart, out_load, slot_free;
	vpos_t               vwdata;
	sums_t               swdata, sat_sum;
	logic [2:0][CW-1:0]  nvec, rd_vec;
	mvn_pkg::rsp_t       out_data;

	logic                ndone, nzero;
	logic [2:0][NW-1:0]  nq;

	logic [5:0]          dneg;
	logic [5:0][DW-1:0]  dmag, dsh;
	logic [5:0][RW-1:0]  ds_n;
	logic [DW-1:0]       orm;
	logic [1:0]          sh;
	logic signed [RW-1:0] ma, mb;
	logic signed [2*RW-1:0] pm;
	logic [2:0]          km1;
	logic signed [SW:0]  s25 [3];

	mvn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nstart),
		.vin    (nvec),
		.done   (ndone),
		.zero   (nzero),
		.q      (nq)
	);

	// pre-shift of the edge vectors so every component fits the RW-bit signed multiplier operands
	always_comb begin
		orm = '0;
		for (int i = 0; i < 6; i++) begin
			dneg[i] = d_q[i][DW-1];
			dmag[i] = dneg[i] ? -d_q[i] : d_q[i];
			orm     = orm | dmag[i];
		end
		if (orm[DW-1]) sh = 2'd3;
		else if (orm[DW-2]) sh = 2'd2;
		else if (orm[DW-3]) sh = 2'd1;
		else sh = 2'd0;
		for (int i = 0; i < 6; i++) begin
			dsh[i]  = dmag[i] >> sh;
			ds_n[i] = dneg[i] ? -RW'(dsh[i]) : RW'(dsh[i]);
		end
	end

	always_comb begin
		case (k_q)
			3'd0: begin ma = ds_q[1]; mb = ds_q[5]; end
			3'd1: begin ma = ds_q[2]; mb = ds_q[4]; end
			3'd2: begin ma = ds_q[2]; mb = ds_q[3]; end
			3'd3: begin ma = ds_q[0]; mb = ds_q[5]; end
			3'd4: begin ma = ds_q[0]; mb = ds_q[4]; end
			3'd5: begin ma = ds_q[1]; mb = ds_q[3]; end
			default: begin ma = ds_q[0]; mb = ds_q[0]; end
		endcase
		pm  = ma * mb;
		km1 = k_q - 3'd1;
	end

	always_comb begin
		case (cn_q)
			2'd0:    cn_addr = ia_q;
			2'd1:    cn_addr = ib_q;
			default: cn_addr = ic_q;
		endcase
		for (int i = 0; i < 3; i++) begin
			s25[i] = (SW + 1)'($signed(srd_q[i])) + (SW + 1)'($signed(nq[i]));
			if (s25[i][SW] != s25[i][SW-1]) begin
				sat_sum[i] = s25[i][SW] ? mvn_pkg::SUM_MIN : mvn_pkg::SUM_MAX;
			end else begin
				sat_sum[i] = s25[i][SW-1:0];
			end
			rd_vec[i] = CW'($signed(srd_q[i]));
		end
		vwdata[0] = head.ent.px;
		vwdata[1] = head.ent.py;
		vwdata[2] = head.ent.pz;
	end

	assign slot_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		nxt      = st_q;
		vaddr    = to_addr(head.ent.ca);
		saddr    = to_addr(head.ent.idx);
		vwe      = 1'b0;
		swe      = 1'b0;
		swaddr   = cn_addr;
		swdata   = sat_sum;
		pop      = 1'b0;
		nstart   = 1'b0;
		nvec     = cr_q;
		out_load = 1'b0;
		out_data.out_index   = ridx_q;
		out_data.normal_x    = nq[0];
		out_data.normal_y    = nq[1];
		out_data.normal_z    = nq[2];
		out_data.zero_normal = nzero;
		case (st_q)
			mvn_pkg::BK_CLEAR: begin
				swe    = 1'b1;
				swaddr = clr_q;
				swdata = '0;
				if (clr_q == AW'(MAX_VERTICES - 1)) nxt = mvn_pkg::BK_IDLE;
			end
			mvn_pkg::BK_IDLE: begin
				if (head.valid) begin
					case (head.ent.op)
						mvn_pkg::OP_WRITE: begin
							vwe = 1'b1;
							pop = 1'b1;
						end
						mvn_pkg::OP_FACE: begin
							pop = 1'b1;
							nxt = mvn_pkg::BK_FA;
						end
						mvn_pkg::OP_READ: begin
							pop = 1'b1;
							nxt = mvn_pkg::BK_RS;
						end
						mvn_pkg::OP_READ_OOR: begin
							out_data.out_index   = head.ent.idx;
							out_data.normal_x    = '0;
							out_data.normal_y    = '0;
							out_data.normal_z    = '0;
							out_data.zero_normal = 1'b1;
							if (slot_free) begin
								out_load = 1'b1;
								pop      = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			mvn_pkg::BK_FA: begin
				vaddr = ib_q;
				nxt   = mvn_pkg::BK_FB;
			end
			mvn_pkg::BK_FB: begin
				vaddr = ic_q;
				nxt   = mvn_pkg::BK_FC;
			end
			mvn_pkg::BK_FC:    nxt = mvn_pkg::BK_SHIFT;
			mvn_pkg::BK_SHIFT: nxt = mvn_pkg::BK_MUL;
			mvn_pkg::BK_MUL:   if (k_q == 3'd6) nxt = mvn_pkg::BK_NGO;
			mvn_pkg::BK_NGO: begin
				nstart = 1'b1;
				nxt    = mvn_pkg::BK_NF;
			end
			mvn_pkg::BK_NF: begin
				// degenerate face adds nothing
				if (ndone) nxt = nzero ? mvn_pkg::BK_IDLE : mvn_pkg::BK_ACC_RD;
			end
			mvn_pkg::BK_ACC_RD: begin
				saddr = cn_addr;
				nxt   = mvn_pkg::BK_ACC_WR;
			end
			mvn_pkg::BK_ACC_WR: begin
				swe = 1'b1;
				nxt = (cn_q == 2'd2) ? mvn_pkg::BK_IDLE : mvn_pkg::BK_ACC_RD;
			end
			mvn_pkg::BK_RS: begin
				swe    = 1'b1;
				swaddr = raddr_q;
				swdata = '0;
				nstart = 1'b1;
				nvec   = rd_vec;
				nxt    = mvn_pkg::BK_RN;
			end
			mvn_pkg::BK_RN: if (ndone) nxt = mvn_pkg::BK_OUT;
			mvn_pkg::BK_OUT: begin
				if (slot_free) begin
					out_load = 1'b1;
					nxt      = mvn_pkg::BK_IDLE;
				end
			end
			default: nxt = mvn_pkg::BK_IDLE;
		endcase
	end

	assign ctl.clearing = (st_q == mvn_pkg::BK_CLEAR);
	assign ctl.pop      = pop;

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[to_addr(head.ent.idx)] <= vwdata;
		end
		vrd_q <= vmem[vaddr];
	end

	always_ff @(posedge clk) begin
		if (swe) begin
			smem[swaddr] <= swdata;
		end
		srd_q <= smem[saddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= mvn_pkg::BK_CLEAR;
			clr_q       <= '0;
			k_q         <= '0;
			cn_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q <= nxt;
			if (st_q == mvn_pkg::BK_CLEAR) clr_q <= clr_q + 1'b1;
			if (st_q == mvn_pkg::BK_SHIFT) k_q <= '0;
			if (st_q == mvn_pkg::BK_MUL) k_q <= k_q + 1'b1;
			if (st_q == mvn_pkg::BK_NF) cn_q <= '0;
			if (st_q == mvn_pkg::BK_ACC_WR) cn_q <= cn_q + 1'b1;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == mvn_pkg::BK_IDLE && head.valid) begin
			ia_q    <= to_addr(head.ent.ca);
			ib_q    <= to_addr(head.ent.cb);
			ic_q    <= to_addr(head.ent.cc);
			ridx_q  <= head.ent.idx;
			raddr_q <= to_addr(head.ent.idx);
		end
		if (st_q == mvn_pkg::BK_FA) va_q <= vrd_q;
		if (st_q == mvn_pkg::BK_FB) vb_q <= vrd_q;
		if (st_q == mvn_pkg::BK_FC) begin
			for (int i = 0; i < 3; i++) begin
				d_q[i]     <= DW'($signed(vb_q[i])) - DW'($signed(va_q[i]));
				d_q[i + 3] <= DW'($signed(vrd_q[i])) - DW'($signed(va_q[i]));
			end
		end
		if (st_q == mvn_pkg::BK_SHIFT) ds_q <= ds_n;
		if (st_q == mvn_pkg::BK_MUL) begin
			if (k_q != 3'd6) prod_q <= pm;
			// odd steps subtract the second product of each component
			if (k_q != 3'd0) begin
				cr_q[km1[2:1]] <= km1[0] ? cr_q[km1[2:1]] - CW'(prod_q) : CW'(prod_q);
			end
		end
		if (out_load) rsp_q <= out_data;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hdl/mesh_vertex_normals_unit.sv]
// Top level of the mesh vertex normal unit: front end, request queue, back end.
// Depends on mvn_pkg, mvn_front and mvn_back.
//
//   channel   dir  handshake             payload
//   request   in   req_valid/req_ready   req (mvn_pkg::req_t)
//   result    out  rsp_valid/rsp_ready   rsp (mvn_pkg::rsp_t)
//
// One request is worked at a time in the back end. A face's run time grows with
// the normalize pre-shift; a degenerate face and a read of a zero sum finish early.
// The square root takes 32 steps and the restoring divider 15 steps per component.
// After reset the normal-sum memory is cleared, with req_ready low.
// A two-entry queue lets requests arrive while the back end works; a held result
// stalls the back end once the next read, in or out of range, has its result ready.
module mesh_vertex_normals_unit #(
	parameter int MAX_VERTICES = mvn_pkg::DEF_MAX_VERTICES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  mvn_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mvn_pkg::rsp_t rsp
);

	mvn_pkg::fr_head_t head;
	mvn_pkg::bk_ctl_t  ctl;

	mvn_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.head      (head),
		.ctl       (ctl)
	);

	mvn_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.ctl       (ctl),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[hdl/mvn_chk.sv]
// Port-level checks of the mesh vertex normal unit, bound to the top level.
// Depends on mvn_pkg and mesh_vertex_normals_unit.
module mvn_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input mvn_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input mvn_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.zero_normal |->
			rsp.normal_x == 0 && rsp.normal_y == 0 && rsp.normal_z == 0)
		else $error("zero flag with nonzero normal");

	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.zero_normal |->
			rsp.normal_x != 0 || rsp.normal_y != 0 || rsp.normal_z != 0)
		else $error("unit normal is zero without flag");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
			rsp.normal_x >= -16384 && rsp.normal_x <= 16384 &&
			rsp.normal_y >= -16384 && rsp.normal_y <= 16384 &&
			rsp.normal_z >= -16384 && rsp.normal_z <= 16384)
		else $error("normal component out of Q1.14 range");

endmodule

bind mesh_vertex_normals_unit mvn_chk u_chk (.*);
